// ----- rtl/core/sbcs_pkg.sv -----
`default_nettype none

package sbcs_pkg;

  localparam int unsigned NumMarks = 3;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REG_DEFAULT_CODE = 2'd0,
    REG_DOT_TICKS    = 2'd1,
    REG_DASH_TICKS   = 2'd2,
    REG_GAP_TICKS    = 2'd3
  } reg_index_t;

  typedef logic [2:0] color_t;
  typedef logic [NumMarks-1:0] dash_mask_t;

  localparam color_t LED_OFF    = 3'd0;
  localparam color_t LED_WHITE  = 3'd1;
  localparam color_t LED_GREEN  = 3'd2;
  localparam color_t LED_BLUE   = 3'd3;
  localparam color_t LED_RED    = 3'd4;
  localparam color_t LED_YELLOW = 3'd5;

  typedef struct packed {
    color_t     color;
    dash_mask_t dash;
  } pattern_t;

  // Bit k of the dash mask is set when mark k is a dash.
  function automatic pattern_t code_pattern(input logic [4:0] code);
    pattern_t p;
    case (code)
      5'd0:    p = '{LED_WHITE,  3'b000};
      5'd1:    p = '{LED_WHITE,  3'b100};
      5'd2:    p = '{LED_WHITE,  3'b111};
      5'd3:    p = '{LED_GREEN,  3'b000};
      5'd4:    p = '{LED_BLUE,   3'b111};
      5'd5:    p = '{LED_BLUE,   3'b101};
      5'd6:    p = '{LED_BLUE,   3'b000};
      5'd7:    p = '{LED_RED,    3'b000};
      5'd8:    p = '{LED_RED,    3'b100};
      5'd9:    p = '{LED_RED,    3'b010};
      5'd10:   p = '{LED_RED,    3'b001};
      5'd11:   p = '{LED_RED,    3'b110};
      5'd12:   p = '{LED_RED,    3'b001};
      5'd13:   p = '{LED_RED,    3'b101};
      5'd14:   p = '{LED_RED,    3'b011};
      5'd15:   p = '{LED_YELLOW, 3'b100};
      5'd16:   p = '{LED_YELLOW, 3'b001};
      5'd17:   p = '{LED_YELLOW, 3'b101};
      5'd18:   p = '{LED_YELLOW, 3'b110};
      5'd19:   p = '{LED_YELLOW, 3'b111};
      default: p = '{LED_RED,    3'b111};
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/status_blink_code_sequencer_top.sv -----
// Channel  Direction  Handshake             Payload
// in       input      in_valid/in_ready     in_opcode, in_status_code
// out      output     out_valid/out_ready   out_led_color, out_accepted, out_sequence_busy
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// For each item the sequencer state is updated and the result is registered at
// the clock edge of the transfer, so one item can enter per cycle while in_ready is high.
// A single output register holds the result; in_ready is high while it is empty
// or being drained, so a stall on out_ready holds off the input side.
// rst_n is synchronous and active low; it restores the register defaults and
// returns the sequencer to idle with the LED off.
`default_nettype none

module status_blink_code_sequencer_top
  import sbcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [0:0] in_opcode,
  input  wire logic [4:0] in_status_code,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_led_color,
  output logic            out_accepted,
  output logic            out_sequence_busy,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  logic [4:0] default_code_r;
  logic [7:0] dot_ticks_r;
  logic [7:0] dash_ticks_r;
  logic [7:0] gap_ticks_r;

  logic [4:0] cur_code_r, cur_code_nxt;
  logic       busy_r, busy_nxt;
  color_t     color_r, color_nxt;
  dash_mask_t dash_r, dash_nxt;
  logic [8:0] mark_idx_r, mark_idx_nxt;
  logic [7:0] lit_cnt_r, lit_cnt_nxt;
  logic       mark_lit_r, mark_lit_nxt;
  color_t     shown_r, shown_nxt;
  logic       accepted_nxt;

  logic       out_valid_r;
  color_t     out_color_r;
  logic       out_accepted_r;
  logic       out_busy_r;

  logic       in_xfer;
  pattern_t   pat;
  logic [7:0] mark_len;
  logic [8:0] gap_end;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign pat     = code_pattern(cur_code_r);
  assign gap_end = 9'(NumMarks) + {1'b0, gap_ticks_r};

  always_comb begin
    cur_code_nxt = cur_code_r;
    busy_nxt     = busy_r;
    color_nxt    = color_r;
    dash_nxt     = dash_r;
    mark_idx_nxt = mark_idx_r;
    lit_cnt_nxt  = lit_cnt_r;
    mark_lit_nxt = mark_lit_r;
    shown_nxt    = shown_r;
    accepted_nxt = 1'b0;
    mark_len     = dot_ticks_r;
    if (opcode_t'(in_opcode) == OP_SET) begin
      if (!busy_r) begin
        cur_code_nxt = in_status_code;
        accepted_nxt = 1'b1;
      end
    end else begin
      if (!busy_r) begin
        busy_nxt  = 1'b1;
        color_nxt = pat.color;
        dash_nxt  = pat.dash;
      end
      if (!mark_lit_r) begin
        shown_nxt    = LED_OFF;
        mark_lit_nxt = 1'b1;
      end else if (mark_idx_r < 9'(NumMarks)) begin
        mark_len    = dash_nxt[mark_idx_r[1:0]] ? dash_ticks_r : dot_ticks_r;
        shown_nxt   = color_nxt;
        lit_cnt_nxt = lit_cnt_r + 8'd1;
        if (lit_cnt_nxt == mark_len) begin
          lit_cnt_nxt  = 8'd0;
          mark_idx_nxt = mark_idx_r + 9'd1;
          mark_lit_nxt = 1'b0;
        end
      end else if (mark_idx_r < gap_end) begin
        mark_idx_nxt = mark_idx_r + 9'd1;
      end else begin
        mark_idx_nxt = 9'd0;
        busy_nxt     = 1'b0;
        cur_code_nxt = default_code_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_code_r <= 5'd0;
      dot_ticks_r    <= 8'd1;
      dash_ticks_r   <= 8'd3;
      gap_ticks_r    <= 8'd4;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_DEFAULT_CODE: default_code_r <= cfg_wdata[4:0];
        REG_DOT_TICKS:    dot_ticks_r    <= cfg_wdata;
        REG_DASH_TICKS:   dash_ticks_r   <= cfg_wdata;
        REG_GAP_TICKS:    gap_ticks_r    <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_code_r <= 5'd0;
      busy_r     <= 1'b0;
      color_r    <= LED_OFF;
      dash_r     <= '0;
      mark_idx_r <= 9'd0;
      lit_cnt_r  <= 8'd0;
      mark_lit_r <= 1'b0;
      shown_r    <= LED_OFF;
    end else if (in_xfer) begin
      cur_code_r <= cur_code_nxt;
      busy_r     <= busy_nxt;
      color_r    <= color_nxt;
      dash_r     <= dash_nxt;
      mark_idx_r <= mark_idx_nxt;
      lit_cnt_r  <= lit_cnt_nxt;
      mark_lit_r <= mark_lit_nxt;
      shown_r    <= shown_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_color_r    <= shown_nxt;
      out_accepted_r <= accepted_nxt;
      out_busy_r     <= busy_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_led_color     = out_color_r;
  assign out_accepted      = out_accepted_r;
  assign out_sequence_busy = out_busy_r;

endmodule

`default_nettype wire

// ----- bench/status_blink_code_sequencer_top_tb.sv -----
`default_nettype none

module status_blink_code_sequencer_top_tb;
  import sbcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    color_t led;
    logic   accepted;
    logic   busy;
  } blink_result_t;

  typedef struct packed {
    logic          cfg_row;
    reg_index_t    reg_idx;
    logic [7:0]    reg_val;
    opcode_t       op;
    logic [4:0]    code;
    logic          typed_in;
    blink_result_t res;
  } plan_row_t;

  localparam blink_result_t NO_TYPED = '0;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [0:0] in_opcode = OP_TICK;
  logic [4:0] in_status_code = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_led_color;
  logic       out_accepted;
  logic       out_sequence_busy;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_DEFAULT_CODE;
  logic [7:0] cfg_wdata = '0;

  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 53;
  int unsigned mismatches = 0;

  blink_result_t owed_results[$];
  plan_row_t     plan[27];

  logic [4:0] dflt_code = 5'd0;
  logic [7:0] dot_len = 8'd1;
  logic [7:0] dash_len = 8'd3;
  logic [7:0] gap_len = 8'd4;

  logic [4:0] cur_code = 5'd0;
  logic       seq_active = 1'b0;
  color_t     pat_color = LED_OFF;
  logic [2:0] pat_dash = 3'b000;
  logic [8:0] step_pos = '0;
  logic [7:0] lit_ticks = '0;
  logic       phase_lit = 1'b0;
  color_t     led_now = LED_OFF;

  status_blink_code_sequencer_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_status_code   (in_status_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_led_color    (out_led_color),
    .out_accepted     (out_accepted),
    .out_sequence_busy(out_sequence_busy),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [5:0] blink_pattern(input logic [4:0] code);
    color_t     hue;
    logic [2:0] dashes;
    if (code < 5'd3) hue = LED_WHITE;
    else if (code == 5'd3) hue = LED_GREEN;
    else if (code < 5'd7) hue = LED_BLUE;
    else if (code < 5'd15 || code > 5'd19) hue = LED_RED;
    else hue = LED_YELLOW;
    case (code)
      5'd0, 5'd3, 5'd6, 5'd7:  dashes = 3'b000;
      5'd1, 5'd8, 5'd15:       dashes = 3'b100;
      5'd5, 5'd13, 5'd17:      dashes = 3'b101;
      5'd9:                    dashes = 3'b010;
      5'd10, 5'd12, 5'd16:     dashes = 3'b001;
      5'd11, 5'd18:            dashes = 3'b110;
      5'd14:                   dashes = 3'b011;
      default:                 dashes = 3'b111;
    endcase
    return {hue, dashes};
  endfunction

  function automatic blink_result_t blink_step(input opcode_t op, input logic [4:0] code);
    blink_result_t r;
    logic [7:0]    mark_len;
    r.accepted = 1'b0;
    if (op == OP_SET) begin
      if (!seq_active) begin
        cur_code = code;
        r.accepted = 1'b1;
      end
    end else begin
      if (!seq_active) begin
        seq_active = 1'b1;
        {pat_color, pat_dash} = blink_pattern(cur_code);
      end
      if (!phase_lit) begin
        led_now = LED_OFF;
        phase_lit = 1'b1;
      end else if (step_pos < NumMarks) begin
        mark_len = pat_dash[step_pos[1:0]] ? dash_len : dot_len;
        led_now = pat_color;
        lit_ticks = lit_ticks + 8'd1;
        if (lit_ticks == mark_len) begin
          lit_ticks = '0;
          step_pos = step_pos + 9'd1;
          phase_lit = 1'b0;
        end
      end else if (step_pos < NumMarks + gap_len) begin
        step_pos = step_pos + 9'd1;
      end else begin
        step_pos = '0;
        seq_active = 1'b0;
        cur_code = dflt_code;
      end
    end
    r.led = led_now;
    r.busy = seq_active;
    return r;
  endfunction

  task automatic send_item(input opcode_t op, input logic [4:0] code,
                           input logic typed_in, input blink_result_t typed_res);
    blink_result_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_status_code <= code;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = blink_step(op, code);
    owed_results.push_back(typed_in ? typed_res : predicted);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEFAULT_CODE: dflt_code = value[4:0];
      REG_DOT_TICKS:    dot_len = value;
      REG_DASH_TICKS:   dash_len = value;
      REG_GAP_TICKS:    gap_len = value;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    blink_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result with none expected, led %0d accepted %0d busy %0d",
                 $time, out_led_color, out_accepted, out_sequence_busy);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        if (out_led_color !== want.led) begin
          $display("%0t: led_color expected %0d got %0d", $time, want.led, out_led_color);
          mismatches++;
        end
        if (out_accepted !== want.accepted) begin
          $display("%0t: accepted expected %0d got %0d", $time, want.accepted,
                   out_accepted);
          mismatches++;
        end
        if (out_sequence_busy !== want.busy) begin
          $display("%0t: sequence_busy expected %0d got %0d", $time, want.busy,
                   out_sequence_busy);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [4:0] dc;
    logic [7:0] dot;
    logic [7:0] dash;
    logic [7:0] gap;
    opcode_t    op;
    plan = '{
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_SET,  5'd31, 1'b1, '{LED_OFF, 1'b1, 1'b0}},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_SET,  5'd0,  1'b1, '{LED_OFF, 1'b1, 1'b0}},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b1, '{LED_OFF, 1'b0, 1'b1}},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_SET,  5'd31, 1'b1, '{LED_OFF, 1'b0, 1'b1}},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b1, REG_GAP_TICKS,    8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_SET,  5'd20, 1'b0, NO_TYPED},
      '{1'b1, REG_DEFAULT_CODE, 8'd19, OP_TICK, 5'd0, 1'b0, NO_TYPED},
      '{1'b1, REG_GAP_TICKS,    8'd4, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b1, REG_DASH_TICKS,   8'd1, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b1, REG_GAP_TICKS,    8'd1, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED},
      '{1'b0, REG_DEFAULT_CODE, 8'd0, OP_TICK, 5'd0,  1'b0, NO_TYPED}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].cfg_row) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].op, plan[i].code, plan[i].typed_in, plan[i].res);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 53;
        recv_idle_pct = 29;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      dc = 5'($urandom_range(0, 31));
      dot = 8'($urandom_range(1, 4));
      dash = 8'($urandom_range(1, 5));
      gap = 8'($urandom_range(0, 6));
      case (ph)
        2: begin
          dc = 5'd31;
          dot = 8'd0;
          dash = 8'($urandom_range(0, 2));
          gap = 8'd0;
        end
        5: begin
          dot = 8'd255;
          dash = 8'd255;
          gap = 8'd255;
        end
        9: begin
          dc = 5'd0;
          dot = 8'd1;
          dash = 8'd1;
          gap = 8'd0;
        end
        10: gap = 8'd255;
        default: ;
      endcase
      wait_idle();
      write_reg(REG_DEFAULT_CODE, {3'($urandom_range(0, 7)), dc});
      write_reg(REG_DOT_TICKS, dot);
      write_reg(REG_DASH_TICKS, dash);
      write_reg(REG_GAP_TICKS, gap);
      for (int n = 0; n < 50; n++) begin
        if (!seq_active) op = ($urandom_range(99) < 60) ? OP_SET : OP_TICK;
        else op = ($urandom_range(99) < 10) ? OP_SET : OP_TICK;
        send_item(op, 5'($urandom_range(0, 31)), 1'b0, NO_TYPED);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/sbcs_pkg.sv
rtl/core/status_blink_code_sequencer_top.sv
bench/status_blink_code_sequencer_top_tb.sv
